[rtl/tsst_pkg.sv]
// ----------------------------------------------------------------------------
// tsst_pkg
// Types, flag and state codes, and the per-side transition function of the
// TCP session state tracker.
// ----------------------------------------------------------------------------
package tsst_pkg;

    localparam logic [7:0] F_FIN = 8'h01;
    localparam logic [7:0] F_SYN = 8'h02;
    localparam logic [7:0] F_RST = 8'h04;
    localparam logic [7:0] F_ACK = 8'h10;
    localparam logic [7:0] F_MASK = F_FIN | F_SYN | F_RST | F_ACK;

    localparam logic [3:0] ST_CLOSED       = 4'd0;
    localparam logic [3:0] ST_LISTEN       = 4'd1;
    localparam logic [3:0] ST_SYN_SENT     = 4'd2;
    localparam logic [3:0] ST_SYN_RCVD     = 4'd3;
    localparam logic [3:0] ST_SYNACK_SENT  = 4'd4;
    localparam logic [3:0] ST_SYNACK_RCVD  = 4'd5;
    localparam logic [3:0] ST_ESTABLISHED  = 4'd6;
    localparam logic [3:0] ST_CLOSE_WAIT_1 = 4'd7;
    localparam logic [3:0] ST_CLOSE_WAIT_2 = 4'd8;
    localparam logic [3:0] ST_LAST_ACK     = 4'd9;
    localparam logic [3:0] ST_FIN_WAIT_1   = 4'd10;
    localparam logic [3:0] ST_FIN_WAIT_2   = 4'd11;
    localparam logic [3:0] ST_CLOSING_1    = 4'd12;
    localparam logic [3:0] ST_CLOSING_2    = 4'd13;
    localparam logic [3:0] ST_TIME_WAIT    = 4'd14;

    typedef struct packed {
        logic [3:0]  state;
        logic [31:0] eack;
        logic        data;
    } side_t;

    typedef struct packed {
        side_t srv;
        side_t cli;
    } row_t;

    localparam int ROW_W = $bits(row_t);

    typedef struct packed {
        logic reset_seen;
        logic step_applied;
        logic ack_mismatch;
    } status_t;

    function automatic side_t side_step(side_t cur, logic is_send, logic [7:0] f,
                                        logic [31:0] seq);
        side_t nxt;
        logic  rcv;
        nxt = cur;
        rcv = !is_send;
        unique case (cur.state)
            ST_CLOSED:
            begin
                if (is_send && f == F_SYN)
                begin
                    nxt.state = ST_SYN_SENT;
                end
                else if (rcv && f == F_SYN)
                begin
                    nxt.state = ST_SYN_RCVD;
                    nxt.eack  = seq;
                end
            end
            ST_SYN_SENT:
            begin
                if (rcv && f == (F_SYN | F_ACK))
                begin
                    nxt.state = ST_SYNACK_RCVD;
                    nxt.eack  = seq;
                end
            end
            ST_SYN_RCVD:
            begin
                if (is_send && f == (F_SYN | F_ACK))
                begin
                    nxt.state = ST_SYNACK_SENT;
                end
            end
            ST_SYNACK_SENT:
            begin
                if (rcv && f == F_ACK)
                begin
                    nxt.state = ST_ESTABLISHED;
                    nxt.data  = 1'b1;
                end
            end
            ST_SYNACK_RCVD:
            begin
                if (is_send && f == F_ACK)
                begin
                    nxt.state = ST_ESTABLISHED;
                    nxt.data  = 1'b1;
                end
            end
            ST_ESTABLISHED:
            begin
                if ((f & F_FIN) != 8'h00)
                begin
                    nxt.state = is_send ? ST_FIN_WAIT_1 : ST_CLOSE_WAIT_1;
                end
            end
            ST_CLOSE_WAIT_1:
            begin
                if (is_send && f == F_ACK)
                begin
                    nxt.state = ST_CLOSE_WAIT_2;
                end
                else if (is_send && f == (F_ACK | F_FIN))
                begin
                    nxt.state = ST_LAST_ACK;
                end
            end
            ST_CLOSE_WAIT_2:
            begin
                if (is_send && (f & F_FIN) != 8'h00)
                begin
                    nxt.state = ST_LAST_ACK;
                end
            end
            ST_LAST_ACK:
            begin
                if (rcv && f == F_ACK)
                begin
                    nxt.state = ST_CLOSED;
                end
            end
            ST_FIN_WAIT_1:
            begin
                if (rcv && f == F_ACK)
                begin
                    nxt.state = ST_FIN_WAIT_2;
                end
                else if (rcv && f == F_FIN)
                begin
                    nxt.state = ST_CLOSING_1;
                end
                else if (rcv && f == (F_FIN | F_ACK))
                begin
                    nxt.state = ST_TIME_WAIT;
                end
            end
            ST_FIN_WAIT_2:
            begin
                if (rcv && (f == F_FIN || f == (F_FIN | F_ACK)))
                begin
                    nxt.state = ST_TIME_WAIT;
                end
            end
            ST_CLOSING_1:
            begin
                if (is_send && f == F_ACK)
                begin
                    nxt.state = ST_CLOSING_2;
                end
            end
            ST_CLOSING_2:
            begin
                if (rcv && f == F_ACK)
                begin
                    nxt.state = ST_TIME_WAIT;
                end
            end
            default:
            begin
                nxt.state = cur.state;
            end
        endcase
        if ((f & F_FIN) != 8'h00)
        begin
            nxt.data = 1'b0;
        end
        return nxt;
    endfunction

endpackage

[rtl/tsst_seg_if.sv]
// ----------------------------------------------------------------------------
// tsst_seg_if
// Segment channel: one TCP header summary per beat.
// ----------------------------------------------------------------------------
interface tsst_seg_if;
    logic        valid;
    logic        ready;
    logic [9:0]  session_slot;
    logic        new_session;
    logic        sender_side;
    logic [7:0]  tcp_flags;
    logic [31:0] seq_number;
    logic [31:0] ack_number;

    modport source (
        output valid, session_slot, new_session, sender_side, tcp_flags,
               seq_number, ack_number,
        input  ready
    );

    modport sink (
        input  valid, session_slot, new_session, sender_side, tcp_flags,
               seq_number, ack_number,
        output ready
    );
endinterface

[rtl/tsst_res_if.sv]
// ----------------------------------------------------------------------------
// tsst_res_if
// Result channel: session state after one segment, one beat per segment.
// ----------------------------------------------------------------------------
interface tsst_res_if;
    logic       valid;
    logic       ready;
    logic [3:0] client_state;
    logic [3:0] server_state;
    logic       client_data_on;
    logic       server_data_on;
    logic       reset_seen;
    logic       step_applied;
    logic       ack_mismatch;

    modport source (
        output valid, client_state, server_state, client_data_on, server_data_on,
               reset_seen, step_applied, ack_mismatch,
        input  ready
    );

    modport sink (
        input  valid, client_state, server_state, client_data_on, server_data_on,
               reset_seen, step_applied, ack_mismatch,
        output ready
    );
endinterface

[rtl/tsst_ram.sv]
// ----------------------------------------------------------------------------
// tsst_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tsst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/tsst_step.sv]
// ----------------------------------------------------------------------------
// tsst_step
// Update of one session row by one segment: init, RST, ack check, and the
// sender and receiver transitions.
// ----------------------------------------------------------------------------
module tsst_step (
    input  tsst_pkg::row_t    row_in,
    input  logic              new_session,
    input  logic              sender_side,
    input  logic [7:0]        tcp_flags,
    input  logic [31:0]       seq_number,
    input  logic [31:0]       ack_number,
    output tsst_pkg::row_t    row_out,
    output tsst_pkg::status_t status
);
    import tsst_pkg::*;

    row_t       row0;
    side_t      snd;
    side_t      rcv;
    side_t      snd_next;
    side_t      rcv_next;
    logic [7:0] fm;

    assign fm = tcp_flags & F_MASK;

    always_comb
    begin
        row0 = row_in;
        if (new_session)
        begin
            row0.cli = '{state: ST_CLOSED, eack: 32'd0, data: 1'b0};
            row0.srv = '{state: ST_CLOSED, eack: 32'd0, data: 1'b0};
        end
        snd = sender_side ? row0.srv : row0.cli;
        rcv = sender_side ? row0.cli : row0.srv;

        snd_next = snd;
        rcv_next = rcv;
        status   = '0;

        priority if ((tcp_flags & F_RST) != 8'h00)
        begin
            snd_next.state = ST_CLOSED;
            snd_next.data  = 1'b0;
            rcv_next.state = ST_CLOSED;
            rcv_next.data  = 1'b0;
            status.reset_seen = 1'b1;
        end
        else if (snd.eack != ack_number)
        begin
            status.ack_mismatch = (snd.state != ST_CLOSED) &&
                                  (rcv.state != ST_LAST_ACK) &&
                                  (rcv.state != ST_TIME_WAIT);
        end
        else
        begin
            snd_next = side_step(snd, 1'b1, fm, seq_number);
            rcv_next = side_step(rcv, 1'b0, fm, seq_number);
            if (!snd_next.data)
            begin
                rcv_next.eack = rcv_next.eack + 32'd1;
            end
            status.step_applied = 1'b1;
        end

        row_out.cli = sender_side ? rcv_next : snd_next;
        row_out.srv = sender_side ? snd_next : rcv_next;
    end

endmodule

[rtl/tcp_session_state_tracker_unit.sv]
// ----------------------------------------------------------------------------
// tcp_session_state_tracker_unit
// Passive TCP connection tracker: read-modify-write of one session row per
// segment, with the handshake and teardown machine for both sides.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  seg      in   session_slot, new_session, sender_side, tcp_flags,
//                seq_number, ack_number
//  result   out  client_state, server_state, client_data_on, server_data_on,
//                reset_seen, step_applied, ack_mismatch
//
// One beat per cycle sustained while the result is not stalled; a segment beat is
// registered together with its row, read from the session RAM at the beat edge; the
// row is then updated and written back as its result is registered.
// The last written row is forwarded so that back-to-back beats on one slot
// see each other. Reset clears only the pipeline valid bits; a slot row holds
// garbage until a beat with new_session. A stalled result holds both stages
// and drops seg.ready once the update stage is full.
// ----------------------------------------------------------------------------
module tcp_session_state_tracker_unit #(
    parameter int SESSION_SLOTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    tsst_seg_if.sink          seg,
    tsst_res_if.source        result
);
    import tsst_pkg::*;

    localparam int AW = (SESSION_SLOTS > 1) ? $clog2(SESSION_SLOTS) : 1;

    function automatic logic [AW-1:0] slot_index(logic [9:0] s);
        logic [10:0] r;
        r = {1'b0, s};
        for (int i = 9; i >= 0; i--)
        begin
            if ((SESSION_SLOTS << i) <= 1023)
            begin
                if (r >= 11'(SESSION_SLOTS << i))
                begin
                    r = r - 11'(SESSION_SLOTS << i);
                end
            end
        end
        return AW'(r);
    endfunction

    logic          seg_acc;
    logic          s1_adv;

    logic          s1_valid_reg;
    logic [AW-1:0] s1_slot_reg;
    logic          s1_new_reg;
    logic          s1_side_reg;
    logic [7:0]    s1_flags_reg;
    logic [31:0]   s1_seq_reg;
    logic [31:0]   s1_ack_reg;

    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_slot_reg;
    row_t          fwd_row_reg;

    logic          res_valid_reg;
    row_t          res_row_reg;
    status_t       res_status_reg;

    logic [ROW_W-1:0] rd_data;
    row_t             row_cur;
    row_t             row_next;
    status_t          status_next;
    logic             wr_en;

    assign s1_adv    = !res_valid_reg || result.ready;
    assign seg.ready = !s1_valid_reg || s1_adv;
    assign seg_acc   = seg.valid && seg.ready;
    assign wr_en     = s1_valid_reg && s1_adv;

    tsst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SESSION_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_slot_reg),
        .wdata (row_next),
        .re    (seg_acc),
        .raddr (slot_index(seg.session_slot)),
        .rdata (rd_data)
    );

    assign row_cur = (fwd_valid_reg && fwd_slot_reg == s1_slot_reg) ? fwd_row_reg
                                                                    : row_t'(rd_data);

    tsst_step u_step (
        .row_in      (row_cur),
        .new_session (s1_new_reg),
        .sender_side (s1_side_reg),
        .tcp_flags   (s1_flags_reg),
        .seq_number  (s1_seq_reg),
        .ack_number  (s1_ack_reg),
        .row_out     (row_next),
        .status      (status_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (seg.ready)
            begin
                s1_valid_reg <= seg.valid;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_adv)
            begin
                res_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (seg_acc)
        begin
            s1_slot_reg  <= slot_index(seg.session_slot);
            s1_new_reg   <= seg.new_session;
            s1_side_reg  <= seg.sender_side;
            s1_flags_reg <= seg.tcp_flags;
            s1_seq_reg   <= seg.seq_number;
            s1_ack_reg   <= seg.ack_number;
        end
        if (wr_en)
        begin
            fwd_slot_reg   <= s1_slot_reg;
            fwd_row_reg    <= row_next;
            res_row_reg    <= row_next;
            res_status_reg <= status_next;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.client_state   = res_row_reg.cli.state;
    assign result.server_state   = res_row_reg.srv.state;
    assign result.client_data_on = res_row_reg.cli.data;
    assign result.server_data_on = res_row_reg.srv.data;
    assign result.reset_seen     = res_status_reg.reset_seen;
    assign result.step_applied   = res_status_reg.step_applied;
    assign result.ack_mismatch   = res_status_reg.ack_mismatch;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for tcp_session_state_tracker_unit. A session table kept
// in the bench predicts the client and server states, the data flags and the
// status bits of every segment beat. Directed handshakes and teardowns come
// first, then guided random sessions with noise, a long result stall, and a
// closing stretch at full rate.
// ----------------------------------------------------------------------------
module tb;
    import tsst_pkg::*;

    localparam int SLOTS          = 1024;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    localparam logic SIDE_CLIENT = 1'b0;
    localparam logic SIDE_SERVER = 1'b1;

    localparam logic [7:0] F_PSH   = 8'h08;
    localparam logic [7:0] F_SPARE = 8'hE8;
    localparam logic [4:0][7:0] STEP_FLAGS = {F_SYN, F_SYN | F_ACK, F_ACK, F_FIN, F_FIN | F_ACK};

    typedef struct packed {
        logic [3:0] client_state;
        logic [3:0] server_state;
        logic       client_data_on;
        logic       server_data_on;
        logic       reset_seen;
        logic       step_applied;
        logic       ack_mismatch;
    } session_report_t;

    logic clk = 1'b0;
    logic rst_n;

    tsst_seg_if seg_if ();
    tsst_res_if res_if ();

    tcp_session_state_tracker_unit #(
        .SESSION_SLOTS (SLOTS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .seg    (seg_if),
        .result (res_if)
    );

    logic [3:0]  sess_state [2*SLOTS];
    logic [31:0] sess_eack  [2*SLOTS];
    logic        sess_data  [2*SLOTS];
    bit          slot_live  [SLOTS];
    logic [9:0]  slot_pool  [8];

    session_report_t expected_reports [$];

    int   err_count;
    int   results_seen;
    bit   src_gaps;
    bit   sink_gaps;
    logic hold_off;
    event hold_start;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_error(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < MAX_PRINTED)
            $display("ERROR result %0d, %s: got %0h, expected %0h", results_seen, what, got, want);
        err_count++;
    endtask

    task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_error(name, got, want);
    endtask

    function automatic logic [3:0] side_next(logic [3:0] st, logic snd, logic [7:0] f);
        logic [3:0] nx;
        nx = st;
        case (st)
            ST_CLOSED:
                if (f == F_SYN)
                    nx = snd ? ST_SYN_SENT : ST_SYN_RCVD;
            ST_SYN_SENT:
                if (!snd && f == (F_SYN | F_ACK))
                    nx = ST_SYNACK_RCVD;
            ST_SYN_RCVD:
                if (snd && f == (F_SYN | F_ACK))
                    nx = ST_SYNACK_SENT;
            ST_SYNACK_SENT:
                if (!snd && f == F_ACK)
                    nx = ST_ESTABLISHED;
            ST_SYNACK_RCVD:
                if (snd && f == F_ACK)
                    nx = ST_ESTABLISHED;
            ST_ESTABLISHED:
                if ((f & F_FIN) != 8'h00)
                    nx = snd ? ST_FIN_WAIT_1 : ST_CLOSE_WAIT_1;
            ST_CLOSE_WAIT_1:
                if (snd && f == F_ACK)
                    nx = ST_CLOSE_WAIT_2;
                else if (snd && f == (F_FIN | F_ACK))
                    nx = ST_LAST_ACK;
            ST_CLOSE_WAIT_2:
                if (snd && (f & F_FIN) != 8'h00)
                    nx = ST_LAST_ACK;
            ST_LAST_ACK:
                if (!snd && f == F_ACK)
                    nx = ST_CLOSED;
            ST_FIN_WAIT_1:
                if (!snd && f == F_ACK)
                    nx = ST_FIN_WAIT_2;
                else if (!snd && f == F_FIN)
                    nx = ST_CLOSING_1;
                else if (!snd && f == (F_FIN | F_ACK))
                    nx = ST_TIME_WAIT;
            ST_FIN_WAIT_2:
                if (!snd && (f == F_FIN || f == (F_FIN | F_ACK)))
                    nx = ST_TIME_WAIT;
            ST_CLOSING_1:
                if (snd && f == F_ACK)
                    nx = ST_CLOSING_2;
            ST_CLOSING_2:
                if (!snd && f == F_ACK)
                    nx = ST_TIME_WAIT;
            default:
                nx = st;
        endcase
        return nx;
    endfunction

    task automatic advance_side(int e, logic snd, logic [7:0] f, logic [31:0] seq);
        logic [3:0] nx;
        nx = side_next(sess_state[e], snd, f);
        if (nx != sess_state[e])
        begin
            if (nx == ST_SYN_RCVD || nx == ST_SYNACK_RCVD)
                sess_eack[e] = seq;
            if (nx == ST_ESTABLISHED)
                sess_data[e] = 1'b1;
        end
        if ((f & F_FIN) != 8'h00)
            sess_data[e] = 1'b0;
        sess_state[e] = nx;
    endtask

    task automatic track_segment(logic [9:0] slot, logic init, logic side, logic [7:0] flags,
                                 logic [31:0] seq, logic [31:0] ack);
        int              cl;
        int              se;
        int              re;
        session_report_t rep;
        cl  = 2 * int'(slot);
        se  = cl + int'(side);
        re  = cl + int'(!side);
        rep = '0;
        if (init)
        begin
            slot_live[slot] = 1'b1;
            sess_state[cl] = ST_CLOSED;
            sess_state[cl+1] = ST_CLOSED;
            sess_data[cl] = 1'b0;
            sess_data[cl+1] = 1'b0;
            sess_eack[cl] = 32'h0;
            sess_eack[cl+1] = 32'h0;
        end
        if ((flags & F_RST) != 8'h00)
        begin
            sess_state[cl] = ST_CLOSED;
            sess_state[cl+1] = ST_CLOSED;
            sess_data[cl] = 1'b0;
            sess_data[cl+1] = 1'b0;
            rep.reset_seen = 1'b1;
        end
        else if (sess_eack[se] != ack)
        begin
            rep.ack_mismatch = sess_state[se] != ST_CLOSED && sess_state[re] != ST_LAST_ACK &&
                               sess_state[re] != ST_TIME_WAIT;
        end
        else
        begin
            advance_side(se, 1'b1, flags & F_MASK, seq);
            advance_side(re, 1'b0, flags & F_MASK, seq);
            if (!sess_data[se])
                sess_eack[re] = sess_eack[re] + 32'd1;
            rep.step_applied = 1'b1;
        end
        rep.client_state   = sess_state[cl];
        rep.server_state   = sess_state[cl+1];
        rep.client_data_on = sess_data[cl];
        rep.server_data_on = sess_data[cl+1];
        expected_reports.push_back(rep);
    endtask

    function automatic logic [31:0] ack_for(logic [9:0] slot, logic init, logic side);
        return init ? 32'h0 : sess_eack[2*int'(slot) + int'(side)];
    endfunction

    task automatic send_segment(logic [9:0] slot, logic init, logic side, logic [7:0] flags,
                                logic [31:0] seq, logic [31:0] ack);
        int gap;
        if (src_gaps && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_if.valid        <= 1'b1;
        seg_if.session_slot <= slot;
        seg_if.new_session  <= init;
        seg_if.sender_side  <= side;
        seg_if.tcp_flags    <= flags;
        seg_if.seq_number   <= seq;
        seg_if.ack_number   <= ack;
        @(posedge clk);
        while (!seg_if.ready)
            @(posedge clk);
        track_segment(slot, init, side, flags, seq, ack);
    endtask

    task automatic send_good(logic [9:0] slot, logic init, logic side, logic [7:0] flags,
                             logic [31:0] seq);
        send_segment(slot, init, side, flags, seq, ack_for(slot, init, side));
    endtask

    task automatic random_segment();
        logic [9:0]  slot;
        logic        init;
        logic        side;
        logic [7:0]  flags;
        logic [31:0] ack;
        logic [3:0]  cs;
        logic [3:0]  ss;
        logic [3:0]  snd_st;
        logic [3:0]  rcv_st;
        int          picks [$];
        int          pick;
        if ($urandom_range(0, 9) < 7)
            slot = slot_pool[$urandom_range(0, 7)];
        else
            slot = 10'($urandom_range(0, SLOTS - 1));
        init  = !slot_live[slot] || ($urandom_range(0, 39) == 0);
        side  = 1'($urandom_range(0, 1));
        flags = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0)
        begin
            cs = init ? ST_CLOSED : sess_state[2*int'(slot)];
            ss = init ? ST_CLOSED : sess_state[2*int'(slot)+1];
            for (int k = 0; k < 10; k++)
            begin
                snd_st = (k % 2 == 1) ? ss : cs;
                rcv_st = (k % 2 == 1) ? cs : ss;
                if (side_next(snd_st, 1'b1, STEP_FLAGS[k / 2]) != snd_st ||
                    side_next(rcv_st, 1'b0, STEP_FLAGS[k / 2]) != rcv_st)
                    picks.push_back(k);
            end
            if (picks.size() == 0)
            begin
                init  = 1'b1;
                side  = SIDE_CLIENT;
                flags = F_SYN;
            end
            else
            begin
                pick  = picks[$urandom_range(0, picks.size() - 1)];
                side  = (pick % 2) == 1;
                flags = STEP_FLAGS[pick / 2];
            end
            if ($urandom_range(0, 3) == 0)
                flags = flags | (8'($urandom) & F_SPARE);
            if ($urandom_range(0, 49) == 0)
                flags = flags | F_RST;
            ack = ack_for(slot, init, side);
            if ($urandom_range(0, 11) == 0)
                ack = ack ^ ($urandom | 32'h1);
        end
        else
        begin
            ack = ($urandom_range(0, 1) == 0) ? ack_for(slot, init, side) : 32'($urandom);
        end
        send_segment(slot, init, side, flags, 32'($urandom), ack);
    endtask

    task automatic test_directed_sessions();
        src_gaps = 1'b1;
        sink_gaps <= 1'b1;
        // client opens; the expected ack wraps past all ones
        send_good(10'd0, 1'b1, SIDE_CLIENT, F_SYN, 32'hFFFF_FFFF);
        send_good(10'd0, 1'b0, SIDE_SERVER, F_SYN | F_ACK, 32'h0);
        send_good(10'd0, 1'b0, SIDE_CLIENT, F_ACK, 32'h1234_5678);
        send_segment(10'd0, 1'b0, SIDE_CLIENT, F_ACK, 32'h0, ~ack_for(10'd0, 1'b0, SIDE_CLIENT));
        send_good(10'd0, 1'b0, SIDE_CLIENT, F_FIN | F_ACK | F_SPARE, 32'h0);
        send_good(10'd0, 1'b0, SIDE_SERVER, F_ACK, 32'h0);
        send_good(10'd0, 1'b0, SIDE_SERVER, F_FIN, 32'h0);
        send_segment(10'd0, 1'b0, SIDE_SERVER, F_ACK, 32'h0, ~ack_for(10'd0, 1'b0, SIDE_SERVER));
        send_good(10'd0, 1'b0, SIDE_CLIENT, F_ACK, 32'h0);
        // fresh slot: mismatch from a closed sender stays silent
        send_segment(10'd1023, 1'b1, SIDE_SERVER, F_ACK, 32'h0, 32'hFFFF_FFFF);
        send_good(10'd1023, 1'b0, SIDE_SERVER, F_SYN, 32'h8000_0000);
        send_good(10'd1023, 1'b0, SIDE_CLIENT, F_SYN | F_ACK, 32'hFFFF_FFFE);
        send_good(10'd1023, 1'b0, SIDE_SERVER, F_ACK, 32'h0);
        send_good(10'd1023, 1'b0, SIDE_SERVER, F_FIN, 32'h0);
        send_good(10'd1023, 1'b0, SIDE_CLIENT, F_FIN, 32'h0);
        send_good(10'd1023, 1'b0, SIDE_SERVER, F_ACK, 32'h0);
        send_good(10'd1023, 1'b0, SIDE_CLIENT, F_ACK, 32'h0);
        send_good(10'd1023, 1'b0, SIDE_CLIENT, F_FIN | F_SYN, 32'h0);
        send_segment(10'd1023, 1'b0, SIDE_SERVER, F_MASK | F_SPARE, 32'hFFFF_FFFF, 32'h0);
        // direct close into time wait, masked-off flags in between
        send_good(10'd2, 1'b1, SIDE_CLIENT, F_SYN, 32'h0);
        send_good(10'd2, 1'b0, SIDE_SERVER, F_SYN | F_ACK, 32'h5555_AAAA);
        send_good(10'd2, 1'b0, SIDE_CLIENT, F_ACK, 32'h0);
        send_good(10'd2, 1'b0, SIDE_CLIENT, F_PSH, 32'h0);
        send_good(10'd2, 1'b0, SIDE_CLIENT, F_FIN, 32'h0);
        send_good(10'd2, 1'b0, SIDE_SERVER, F_FIN | F_ACK, 32'h0);
        send_good(10'd2, 1'b0, SIDE_CLIENT, F_SYN, 32'h0);
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < 8; i++)
            slot_pool[i] = 10'($urandom_range(0, SLOTS - 1));
        src_gaps = 1'b1;
        sink_gaps <= 1'b1;
        repeat (count) random_segment();
    endtask

    task automatic test_backpressure();
        src_gaps = 1'b0;
        -> hold_start;
        repeat (60) random_segment();
        src_gaps = 1'b1;
    endtask

    task automatic test_streaming();
        src_gaps = 1'b0;
        sink_gaps <= 1'b0;
        repeat (250) random_segment();
    endtask

    initial
    begin
        hold_off = 1'b0;
        forever
        begin
            @(hold_start);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_if.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (sink_gaps && $urandom_range(0, 7) == 0)
            begin
                res_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 11);
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        session_report_t got;
        session_report_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{res_if.client_state, res_if.server_state, res_if.client_data_on,
                    res_if.server_data_on, res_if.reset_seen, res_if.step_applied,
                    res_if.ack_mismatch};
            if (expected_reports.size() == 0)
            begin
                report_error("result without a pending segment", 32'(got), 32'h0);
            end
            else
            begin
                want = expected_reports.pop_front();
                cmp_field("client_state", 32'(got.client_state), 32'(want.client_state));
                cmp_field("server_state", 32'(got.server_state), 32'(want.server_state));
                cmp_field("client_data_on", 32'(got.client_data_on),
                          32'(want.client_data_on));
                cmp_field("server_data_on", 32'(got.server_data_on),
                          32'(want.server_data_on));
                cmp_field("reset_seen", 32'(got.reset_seen), 32'(want.reset_seen));
                cmp_field("step_applied", 32'(got.step_applied), 32'(want.step_applied));
                cmp_field("ack_mismatch", 32'(got.ack_mismatch), 32'(want.ack_mismatch));
            end
            results_seen++;
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout after %0d idle cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        seg_if.valid        = 1'b0;
        seg_if.session_slot = '0;
        seg_if.new_session  = 1'b0;
        seg_if.sender_side  = 1'b0;
        seg_if.tcp_flags    = '0;
        seg_if.seq_number   = '0;
        seg_if.ack_number   = '0;
        err_count           = 0;
        results_seen        = 0;
        src_gaps            = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            slot_live[i] = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_sessions();
        test_random_traffic(600);
        test_backpressure();
        test_random_traffic(300);
        test_streaming();

        seg_if.valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[tcp_session_state_tracker_unit.f]
rtl/tsst_pkg.sv
rtl/tsst_seg_if.sv
rtl/tsst_res_if.sv
rtl/tsst_ram.sv
rtl/tsst_step.sv
rtl/tcp_session_state_tracker_unit.sv
dv/tb.sv
